>>> rtl/urm_pkg.sv
// Package for the ultrasonic range meter: widths, reset values, register
// indexes, display codes and the seven-segment decode. No dependencies.
`default_nettype none

package urm_pkg;

    // Echo counter and display geometry
    localparam int CountWidth = 16;
    localparam int DigitCount = 5;
    localparam int ScanWidth  = $clog2(DigitCount);
    localparam int PosWidth   = 3;
    localparam int DistWidth  = 14;
    localparam int BcdDigits  = 5;

    // Configuration register widths
    localparam int PeriodWidth   = 24;
    localparam int PulseWidth    = 8;
    localparam int HoldWidth     = 16;
    localparam int CfgDataWidth  = 24;
    localparam int CfgIndexWidth = 2;

    // distance = floor(ticks * 17 / 100), tracked as quotient and remainder
    localparam int RemWidth = 7;
    localparam logic [RemWidth-1:0] RemStep = 7'd17;
    localparam logic [RemWidth-1:0] RemMod  = 7'd100;
    localparam logic [DistWidth-1:0] DistSat = '1;

    // Reset values of the registers
    localparam logic [PeriodWidth-1:0] PeriodReset = 24'd800000;
    localparam logic [PulseWidth-1:0]  PulseReset  = 8'd20;
    localparam logic [DistWidth-1:0]   MaxReset    = 14'd4000;
    localparam logic [HoldWidth-1:0]   HoldReset   = 16'd400;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_TRIGGER_PERIOD,
        REG_TRIGGER_WIDTH,
        REG_MAX_DISTANCE,
        REG_DIGIT_HOLD
    } cfg_index_t;

    typedef logic [4:0] code_t;
    typedef logic [3:0] bcd_t;
    typedef bcd_t [BcdDigits-1:0] bcd_vec_t;

    localparam code_t CodeDash  = 5'd16;
    localparam code_t CodePoint = 5'd17;
    localparam code_t CodeBlank = 5'd18;

    localparam int PointPos     = 3;
    localparam int ThousandsPos = 4;

    function automatic code_t reset_code(input int unsigned pos);
        code_t c;
        if (pos == PointPos) begin
            c = CodePoint;
        end else if (pos > ThousandsPos) begin
            c = CodeBlank;
        end else begin
            c = '0;
        end
        return c;
    endfunction

    // Decimal counter increment, ripple of carries through the digits
    function automatic bcd_vec_t bcd_increment(input bcd_vec_t v);
        bcd_vec_t r;
        logic     carry;
        r     = v;
        carry = 1'b1;
        for (int i = 0; i < BcdDigits; i++) begin
            if (carry) begin
                if (v[i] == 4'd9) begin
                    r[i]  = 4'd0;
                end else begin
                    r[i]  = v[i] + 4'd1;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // bit0 a .. bit6 g, bit7 point
    function automatic logic [7:0] seg_lookup(input code_t code);
        logic [7:0] s;
        case (code)
            5'd0:  s = 8'h3f;
            5'd1:  s = 8'h06;
            5'd2:  s = 8'h5b;
            5'd3:  s = 8'h4f;
            5'd4:  s = 8'h66;
            5'd5:  s = 8'h6d;
            5'd6:  s = 8'h7d;
            5'd7:  s = 8'h07;
            5'd8:  s = 8'h7f;
            5'd9:  s = 8'h6f;
            5'd10: s = 8'h77;
            5'd11: s = 8'h7c;
            5'd12: s = 8'h39;
            5'd13: s = 8'h5e;
            5'd14: s = 8'h79;
            5'd15: s = 8'h71;
            5'd16: s = 8'h40;
            5'd17: s = 8'h80;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ultrasonic_range_meter.sv
// Ultrasonic range meter top level: echo timing, distance, display scan and trigger.
// Depends on urm_pkg.
`default_nettype none

// Usage
//   s_* channel: one word per 1 us tick, carrying the sampled echo level.
//   m_* channel: one word per input word: trigger level, the display position
//   and its segments, a done flag on the tick the echo falls, and the latest
//   distance in mm with its out-of-range flag.
//   cfg_*: write-only register port, one write per cycle while cfg_we is high.
//   Write only while no word is in flight.
// Path: a word accepted on s_* passes two register stages, the input word and
//   then the result word, before it appears on m_*. Throughput: one word per
//   cycle while m_ready is high. The distance is kept as a running quotient,
//   remainder and decimal count that move by at most one step per tick, so the
//   falling edge only copies them out and no divider is needed.
// Reset (aresetn low, synchronous): registers take their defaults, the display
//   shows 0.000, the first trigger pulse starts with the first word.
// Stall: with m_ready low the result word holds; one more word is taken into
//   the input register, after which s_ready drops until the result drains.
module ultrasonic_range_meter (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [urm_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  wire logic [urm_pkg::CfgDataWidth-1:0]    cfg_wdata,
    // input words
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_echo_level,
    // result words
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_trigger,
    output logic [urm_pkg::PosWidth-1:0]             m_digit_position,
    output logic [7:0]                               m_segments,
    output logic                                     m_measure_done,
    output logic [urm_pkg::DistWidth-1:0]            m_distance_mm,
    output logic                                     m_out_of_range
);
    import urm_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [PeriodWidth-1:0] period_cfg_reg;
    logic [PulseWidth-1:0]  pulse_cfg_reg;
    logic [DistWidth-1:0]   max_cfg_reg;
    logic [HoldWidth-1:0]   hold_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_cfg_reg <= PeriodReset;
            pulse_cfg_reg  <= PulseReset;
            max_cfg_reg    <= MaxReset;
            hold_cfg_reg   <= HoldReset;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                REG_TRIGGER_PERIOD: period_cfg_reg <= cfg_wdata[PeriodWidth-1:0];
                REG_TRIGGER_WIDTH:  pulse_cfg_reg  <= cfg_wdata[PulseWidth-1:0];
                REG_MAX_DISTANCE:   max_cfg_reg    <= cfg_wdata[DistWidth-1:0];
                REG_DIGIT_HOLD:     hold_cfg_reg   <= cfg_wdata[HoldWidth-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic echo_in_reg;
    logic out_valid_reg;
    logic advance;

    // Move the held word into the result register when that register is free
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            echo_in_reg <= s_echo_level;
        end
    end

    // ------------------------------------------------------------------
    // Measurement and display state
    // ------------------------------------------------------------------
    logic                   echo_prev_reg, echo_prev_next;
    logic [CountWidth-1:0]  ticks_reg, ticks_next;
    logic                   overflow_reg, overflow_next;
    logic [RemWidth-1:0]    rem_reg, rem_next;
    logic [DistWidth-1:0]   run_dist_reg, run_dist_next;
    bcd_vec_t               bcd_reg, bcd_next;
    logic [DistWidth-1:0]   dist_reg, dist_next;
    logic                   bad_reg, bad_next;
    code_t                  codes_reg [DigitCount];
    code_t                  codes_next [DigitCount];
    logic [PeriodWidth-1:0] period_cnt_reg, period_cnt_next;
    logic [HoldWidth-1:0]   hold_cnt_reg, hold_cnt_next;
    logic [ScanWidth-1:0]   scan_reg, scan_next;

    // result word
    logic                   trig_reg, trig_next;
    logic [PosWidth-1:0]    pos_reg, pos_next;
    logic [7:0]             seg_reg, seg_next;
    logic                   done_reg, done_next;

    // datapath intermediates
    logic [RemWidth-1:0]    rem_sum;
    logic                   bad_now;
    logic [PeriodWidth:0]   period_inc;
    logic [PeriodWidth:0]   period_lim;
    logic [HoldWidth:0]     hold_inc;
    logic [HoldWidth:0]     hold_lim;

    always_comb begin
        echo_prev_next  = echo_prev_reg;
        ticks_next      = ticks_reg;
        overflow_next   = overflow_reg;
        rem_next        = rem_reg;
        run_dist_next   = run_dist_reg;
        bcd_next        = bcd_reg;
        dist_next       = dist_reg;
        bad_next        = bad_reg;
        codes_next      = codes_reg;
        period_cnt_next = period_cnt_reg;
        hold_cnt_next   = hold_cnt_reg;
        scan_next       = scan_reg;
        done_next       = 1'b0;

        rem_sum = rem_reg + RemStep;
        bad_now = (run_dist_reg > max_cfg_reg) || overflow_reg;

        // Measurement: count while echo is high, publish on the falling edge
        if (echo_in_reg) begin
            if (ticks_reg == {CountWidth{1'b1}}) begin
                // counter wraps: restart the running distance, mark overflow
                ticks_next    = '0;
                overflow_next = 1'b1;
                rem_next      = '0;
                run_dist_next = '0;
                bcd_next      = '0;
            end else begin
                ticks_next = ticks_reg + 1'b1;
                if (rem_sum >= RemMod) begin
                    rem_next = rem_sum - RemMod;
                    if (run_dist_reg != DistSat) begin
                        run_dist_next = run_dist_reg + 1'b1;
                        bcd_next      = bcd_increment(bcd_reg);
                    end
                end else begin
                    rem_next = rem_sum;
                end
            end
        end else if (echo_prev_reg) begin
            dist_next = run_dist_reg;
            bad_next  = bad_now;
            if (bad_now) begin
                codes_next[0]            = CodeDash;
                codes_next[1]            = CodeDash;
                codes_next[2]            = CodeDash;
                codes_next[ThousandsPos] = CodeDash;
            end else begin
                codes_next[0]            = {1'b0, bcd_reg[0]};
                codes_next[1]            = {1'b0, bcd_reg[1]};
                codes_next[2]            = {1'b0, bcd_reg[2]};
                codes_next[ThousandsPos] = {1'b0, bcd_reg[3]};
            end
            ticks_next    = '0;
            overflow_next = 1'b0;
            rem_next      = '0;
            run_dist_next = '0;
            bcd_next      = '0;
            done_next     = 1'b1;
        end
        echo_prev_next = echo_in_reg;

        // Display uses the codes as updated by this tick
        pos_next = PosWidth'(scan_reg);
        seg_next = seg_lookup(codes_next[scan_reg]);

        // Trigger pulse; a zero period behaves as one
        trig_next  = period_cnt_reg < {{(PeriodWidth-PulseWidth){1'b0}}, pulse_cfg_reg};
        period_inc = {1'b0, period_cnt_reg} + 1'b1;
        period_lim = (period_cfg_reg == '0) ? (PeriodWidth+1)'(1) : {1'b0, period_cfg_reg};
        period_cnt_next = (period_inc >= period_lim) ? '0 : period_inc[PeriodWidth-1:0];

        // Scan: advance position after each hold interval; zero hold as one
        hold_inc = {1'b0, hold_cnt_reg} + 1'b1;
        hold_lim = (hold_cfg_reg == '0) ? (HoldWidth+1)'(1) : {1'b0, hold_cfg_reg};
        if (hold_inc >= hold_lim) begin
            hold_cnt_next = '0;
            scan_next = (scan_reg == ScanWidth'(DigitCount-1)) ? '0 : scan_reg + 1'b1;
        end else begin
            hold_cnt_next = hold_inc[HoldWidth-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            echo_prev_reg  <= 1'b0;
            ticks_reg      <= '0;
            overflow_reg   <= 1'b0;
            rem_reg        <= '0;
            run_dist_reg   <= '0;
            bcd_reg        <= '0;
            dist_reg       <= '0;
            bad_reg        <= 1'b0;
            period_cnt_reg <= '0;
            hold_cnt_reg   <= '0;
            scan_reg       <= '0;
            for (int i = 0; i < DigitCount; i++) begin
                codes_reg[i] <= reset_code(i);
            end
        end else if (advance) begin
            echo_prev_reg  <= echo_prev_next;
            ticks_reg      <= ticks_next;
            overflow_reg   <= overflow_next;
            rem_reg        <= rem_next;
            run_dist_reg   <= run_dist_next;
            bcd_reg        <= bcd_next;
            dist_reg       <= dist_next;
            bad_reg        <= bad_next;
            period_cnt_reg <= period_cnt_next;
            hold_cnt_reg   <= hold_cnt_next;
            scan_reg       <= scan_next;
            codes_reg      <= codes_next;
        end
    end

    // Result word payload: load on advance, hold while stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            trig_reg <= trig_next;
            pos_reg  <= pos_next;
            seg_reg  <= seg_next;
            done_reg <= done_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_trigger        = trig_reg;
    assign m_digit_position = pos_reg;
    assign m_segments       = seg_reg;
    assign m_measure_done   = done_reg;
    // distance and range flag are state: after a word they equal its view
    assign m_distance_mm    = dist_reg;
    assign m_out_of_range   = bad_reg;

`ifndef SYNTH
    // Remainder of the running distance stays a proper remainder
    assert property (@(posedge aclk) disable iff (!aresetn) rem_reg < RemMod)
        else $error("distance remainder out of range");

    // Scan position never leaves the display
    assert property (@(posedge aclk) disable iff (!aresetn)
        scan_reg <= ScanWidth'(DigitCount-1))
        else $error("scan position out of range");

    // A result shown as digits lies within the limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_measure_done && !m_out_of_range) |-> (m_distance_mm <= max_cfg_reg))
        else $error("in-range distance above limit");

    // An input word held back means the input register is full
    assert property (@(posedge aclk) disable iff (!aresetn) !s_ready |-> in_valid_reg)
        else $error("input stalled with empty input register");
`endif

endmodule

`default_nettype wire

>>> tb/ultrasonic_range_meter_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for ultrasonic_range_meter: echo pulses in, one reading word
// out per tick, each reading compared with a tick-by-tick predictor. Depends on urm_pkg.
module ultrasonic_range_meter_tb;

    import urm_pkg::*;

    // One reading word in the order of the m_* ports
    typedef struct packed {
        logic                trigger;
        logic [PosWidth-1:0] position;
        logic [7:0]          segments;
        logic                done;
        logic [DistWidth-1:0] distance;
        logic                out_of_range;
    } reading_t;

    // Directed echo pulse: stage selects the register setting, then high_ticks
    // words with echo high and low_ticks words with echo low. Where typed is set,
    // the first low word must carry dist_mm/oor as written here.
    typedef struct packed {
        logic [1:0]  stage;
        logic [16:0] high_ticks;
        logic [7:0]  low_ticks;
        logic        typed;
        logic [13:0] dist_mm;
        logic        oor;
    } pulse_row_t;

    localparam logic [7:0] DIGIT_FONT [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };
    localparam logic [7:0] SEG_DASH  = 8'h40;
    localparam logic [7:0] SEG_POINT = 8'h80;
    localparam int unsigned HOLD_OFF_CYCLES = 80;

    pulse_row_t pulse_plan [12] = '{
        // reset settings: period 800000, width 20, limit 4000, hold 400
        '{2'd0, 17'd0,     8'd1, 1'b1, 14'd0,     1'b0},  // display right after reset
        '{2'd0, 17'd1,     8'd2, 1'b1, 14'd0,     1'b0},  // single tick rounds down
        '{2'd0, 17'd5,     8'd2, 1'b1, 14'd0,     1'b0},
        '{2'd0, 17'd6,     8'd2, 1'b1, 14'd1,     1'b0},  // first tick count giving 1 mm
        '{2'd0, 17'd100,   8'd3, 1'b1, 14'd17,    1'b0},
        '{2'd0, 17'd59,    8'd2, 1'b1, 14'd10,    1'b0},
        '{2'd0, 17'd77,    8'd4, 1'b0, 14'd0,     1'b0},
        // longest period, widest pulse, limit 10, longest hold
        '{2'd1, 17'd59,    8'd3, 1'b1, 14'd10,    1'b0},  // exactly at the limit
        '{2'd1, 17'd65,    8'd3, 1'b1, 14'd11,    1'b1},  // one above: dashes
        '{2'd1, 17'd60,    8'd3, 1'b1, 14'd10,    1'b0},  // back in range
        // period 1 (pulse wider than period), limit 9999, fastest scan
        '{2'd2, 17'd41,    8'd6, 1'b1, 14'd6,     1'b0},
        '{2'd2, 17'd2,     8'd6, 1'b1, 14'd0,     1'b0}
    };

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic                     s_echo_level;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_trigger;
    logic [PosWidth-1:0]      m_digit_position;
    logic [7:0]               m_segments;
    logic                     m_measure_done;
    logic [DistWidth-1:0]     m_distance_mm;
    logic                     m_out_of_range;

    // Predicted register contents
    logic [PeriodWidth-1:0] trig_period;
    logic [PulseWidth-1:0]  trig_width;
    logic [DistWidth-1:0]   dist_limit;
    logic [HoldWidth-1:0]   scan_hold;

    // Predicted measurement and display state
    logic                  echo_was_high;
    logic [CountWidth-1:0] echo_ticks;
    logic                  wrapped;
    logic [DistWidth-1:0]  last_distance;
    logic                  last_bad;
    code_t                 shown_codes [DigitCount];
    int unsigned           period_count;
    int unsigned           hold_count;
    int unsigned           scan_pos;

    reading_t    pending_readings [$];
    int unsigned mismatch_count;
    bit          calm;
    bit          hold_off_go;
    int unsigned hold_off_left;

    ultrasonic_range_meter u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_echo_level     (s_echo_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_trigger        (m_trigger),
        .m_digit_position (m_digit_position),
        .m_segments       (m_segments),
        .m_measure_done   (m_measure_done),
        .m_distance_mm    (m_distance_mm),
        .m_out_of_range   (m_out_of_range)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Hard stop in case the block hangs or drops a word
    initial begin
        #30_000_000;
        $display("FAIL ultrasonic_range_meter");
        $finish;
    end

    // Advance the predictor by one tick and return the reading it owes.
    // Measurement first, then the display from the fresh codes, then the counters.
    function automatic reading_t predict_reading(input logic echo);
        reading_t    r;
        int unsigned dist_val;
        int unsigned period_lim;
        int unsigned hold_lim;
        code_t       code;
        r = '0;
        period_lim = (trig_period == '0) ? 1 : int'(trig_period);
        hold_lim   = (scan_hold == '0) ? 1 : int'(scan_hold);

        if (echo) begin
            // count modulo the counter width; a wrap marks the reading bad
            if (echo_ticks == '1) begin
                echo_ticks = '0;
                wrapped    = 1'b1;
            end else begin
                echo_ticks = echo_ticks + 1'b1;
            end
        end else if (echo_was_high) begin
            // falling edge: distance = floor(ticks * 17 / 100), saturated
            dist_val = (int'(echo_ticks) * 17) / 100;
            if (dist_val > 16383) dist_val = 16383;
            last_distance = DistWidth'(dist_val);
            last_bad      = (last_distance > dist_limit) || wrapped;
            if (last_bad) begin
                shown_codes[0] = CodeDash;
                shown_codes[1] = CodeDash;
                shown_codes[2] = CodeDash;
                shown_codes[4] = CodeDash;
            end else begin
                shown_codes[0] = code_t'(dist_val % 10);
                shown_codes[1] = code_t'((dist_val / 10) % 10);
                shown_codes[2] = code_t'((dist_val / 100) % 10);
                shown_codes[4] = code_t'((dist_val / 1000) % 10);
            end
            echo_ticks = '0;
            wrapped    = 1'b0;
            r.done     = 1'b1;
        end
        echo_was_high = echo;

        code = shown_codes[scan_pos];
        if (code < 10)              r.segments = DIGIT_FONT[code];
        else if (code == CodeDash)  r.segments = SEG_DASH;
        else if (code == CodePoint) r.segments = SEG_POINT;
        else                        r.segments = 8'h00;
        r.position     = PosWidth'(scan_pos);
        r.trigger      = (period_count < int'(trig_width));
        r.distance     = last_distance;
        r.out_of_range = last_bad;

        period_count++;
        if (period_count >= period_lim) period_count = 0;
        hold_count++;
        if (hold_count >= hold_lim) begin
            hold_count = 0;
            scan_pos   = (scan_pos + 1) % DigitCount;
        end
        return r;
    endfunction

    // Offer one echo word, idling at random first; record its reading once taken.
    // typed replaces the predicted distance and range flag with hand-written values.
    task automatic offer_word(input logic echo, input bit typed = 1'b0,
                              input logic [DistWidth-1:0] typed_dist = '0,
                              input bit oor = 1'b0);
        reading_t r;
        @(negedge aclk);
        while (!calm && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_echo_level <= echo;
        do @(posedge aclk); while (!s_ready);
        r = predict_reading(echo);
        if (typed) begin
            r.distance     = typed_dist;
            r.out_of_range = oor;
        end
        pending_readings.push_back(r);
    endtask

    // Drop valid and wait for every owed reading, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CfgDataWidth-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        // registers keep only their own width
        case (idx)
            REG_TRIGGER_PERIOD: trig_period = value[PeriodWidth-1:0];
            REG_TRIGGER_WIDTH:  trig_width  = value[PulseWidth-1:0];
            REG_MAX_DISTANCE:   dist_limit  = value[DistWidth-1:0];
            REG_DIGIT_HOLD:     scan_hold   = value[HoldWidth-1:0];
            default: ;
        endcase
    endtask

    task automatic program_registers(input logic [CfgDataWidth-1:0] period_v, width_v,
                                     limit_v, hold_v);
        write_register(REG_TRIGGER_PERIOD, period_v);
        write_register(REG_TRIGGER_WIDTH, width_v);
        write_register(REG_MAX_DISTANCE, limit_v);
        write_register(REG_DIGIT_HOLD, hold_v);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Receiver: random ready, with one long hold-off counted here on request
    initial begin
        m_ready       = 1'b0;
        hold_off_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_off_go) begin
                hold_off_left = HOLD_OFF_CYCLES;
                hold_off_go   = 1'b0;
            end
            if (hold_off_left > 0) begin
                m_ready <= 1'b0;
                hold_off_left--;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= 19);
            end
        end
    end

    // Compare every taken reading word with the oldest owed one
    always @(posedge aclk) begin
        reading_t got;
        reading_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            got = {m_trigger, m_digit_position, m_segments, m_measure_done,
                   m_distance_mm, m_out_of_range};
            if (pending_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected reading word at %0t ns", $time);
            end else begin
                want = pending_readings.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"reading mismatch at %0t ns: expected trig %0b pos %0d ",
                                  "seg %h done %0b dist %0d oor %0b, got trig %0b pos %0d ",
                                  "seg %h done %0b dist %0d oor %0b"}, $time,
                                 want.trigger, want.position, want.segments, want.done,
                                 want.distance, want.out_of_range,
                                 got.trigger, got.position, got.segments, got.done,
                                 got.distance, got.out_of_range);
                end
            end
        end
    end

    initial begin
        int unsigned stage;
        int unsigned words;
        int unsigned high;
        int unsigned low;
        int unsigned pick;

        // hold every input at a known value through reset
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_TRIGGER_PERIOD;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_echo_level   = 1'b0;
        calm           = 1'b0;
        hold_off_go    = 1'b0;
        mismatch_count = 0;

        // predictor starts from the reset state: display shows 0.000
        trig_period   = 24'd800000;
        trig_width    = 8'd20;
        dist_limit    = 14'd4000;
        scan_hold     = 16'd400;
        echo_was_high = 1'b0;
        echo_ticks    = '0;
        wrapped       = 1'b0;
        last_distance = '0;
        last_bad      = 1'b0;
        foreach (shown_codes[i]) shown_codes[i] = (i == 3) ? CodePoint : code_t'(0);
        period_count  = 0;
        hold_count    = 0;
        scan_pos      = 0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed pulses: walk the plan, reprogram when the stage changes
        stage = 0;
        foreach (pulse_plan[i]) begin
            if (pulse_plan[i].stage != stage) begin
                settle();
                stage = pulse_plan[i].stage;
                if (stage == 1)
                    program_registers(24'hffffff, 24'd255, 24'd10, 24'd65535);
                else
                    program_registers(24'd1, 24'd255, 24'd9999, 24'd1);
            end
            repeat (pulse_plan[i].high_ticks) offer_word(1'b1);
            for (int k = 0; k < int'(pulse_plan[i].low_ticks); k++)
                offer_word(1'b0, pulse_plan[i].typed && k == 0,
                           pulse_plan[i].dist_mm, pulse_plan[i].oor);
        end

        // Random phases; junk sits above the width, limit and hold register widths to check masking.
        // Phase 0 takes zero period, zero hold and zero limit.
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            if (ph == 0)
                program_registers(24'd0, {16'($urandom), 8'($urandom_range(1, 3))},
                                  {10'($urandom), 14'd0}, {8'($urandom), 16'd0});
            else
                program_registers(24'($urandom_range(1, 40)),
                                  {16'($urandom),
                                   8'((ph == 3) ? 1 : $urandom_range(1, 45))},
                                  {10'($urandom), 14'($urandom_range(0, 15))},
                                  {8'($urandom), 16'($urandom_range(1, 6))});
            calm        = (ph == 2);
            hold_off_go = (ph == 1);   // stall the result side while words keep coming
            words = 0;
            while (words < 60) begin
                if ($urandom_range(99) < 80) begin
                    // well-formed echo pulse, mostly short
                    pick = $urandom_range(99);
                    high = (pick < 88) ? $urandom_range(1, 24) : $urandom_range(25, 60);
                    low  = $urandom_range(1, 6);
                    repeat (high) offer_word(1'b1);
                    repeat (low) offer_word(1'b0);
                    words += high + low;
                end else begin
                    // noise: glitches and broken pulses
                    low = $urandom_range(1, 8);
                    repeat (low) offer_word(1'($urandom));
                    words += low;
                end
            end
        end
        calm = 1'b0;

        settle();
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("PASS ultrasonic_range_meter");
        else
            $display("FAIL ultrasonic_range_meter");
        $finish;
    end

endmodule

>>> ultrasonic_range_meter.f
rtl/urm_pkg.sv
rtl/ultrasonic_range_meter.sv
tb/ultrasonic_range_meter_tb.sv
